@@ rtl/midplane_irq_status_registers_assert.svh @@
// assertion macros shared by the midplane irq status register rtl
`ifndef MIDPLANE_IRQ_STATUS_REGISTERS_ASSERT_SVH
`define MIDPLANE_IRQ_STATUS_REGISTERS_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MIRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// implication checked in the cycle after the antecedent
`define MIRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mirq_pkg.sv @@
`default_nettype none

package mirq_pkg;

    // command codes
    localparam logic [2:0] CMD_READ   = 3'd0;
    localparam logic [2:0] CMD_WRITE  = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_INSERT = 3'd4;

    // register offsets
    localparam logic [7:0] OFF_NSTAT0_LO = 8'h10;
    localparam logic [7:0] OFF_NSTAT0_HI = 8'h13;
    localparam logic [7:0] OFF_NSTAT1_LO = 8'h18;
    localparam logic [7:0] OFF_NSTAT1_HI = 8'h1b;
    localparam logic [7:0] OFF_NMASK0    = 8'h20;
    localparam logic [7:0] OFF_NMASK1    = 8'h28;
    localparam logic [7:0] OFF_MGMT      = 8'h40;
    localparam logic [7:0] OFF_TEST      = 8'h48;
    localparam logic [7:0] OFF_PA_STATUS = 8'h50;
    localparam logic [7:0] OFF_PA_CTRL   = 8'h58;
    localparam logic [7:0] OFF_OIR       = 8'h70;
    localparam logic [7:0] OFF_SKIP      = 8'h7b;

    // fixed values
    localparam logic [31:0] MGMT_MASK  = 32'h6666_6600;
    localparam logic [31:0] TEST_VALUE = 32'hFFFF_FFFF;
    localparam logic [31:0] BAY0_POWER = 32'h0000_0006;

    localparam int NUM_BAYS  = 6;
    localparam int NUM_SLOTS = 7;

    // power bits per bay 1..6
    localparam logic [31:0] BAY_POWER [NUM_BAYS] = '{
        32'h0000_0600, 32'h0000_6000, 32'h0600_0000,
        32'h0006_0000, 32'h6000_0000, 32'h0060_0000
    };

    // one accepted input beat, cmd in the low bits
    typedef struct packed {
        logic [2:0]  port;
        logic [2:0]  slot;
        logic [31:0] write_data;
        logic [7:0]  offset;
        logic [2:0]  cmd;
    } t_item;

    // one result beat, read_data in the low bits
    typedef struct packed {
        logic        oir_irq_clear;
        logic        mgmt_irq_clear;
        logic        net_irq_line;
        logic [31:0] read_data;
    } t_result;

    // status word that holds a slot's byte lane
    function automatic logic slot_word(input logic [2:0] slot);
        logic w;
        case (slot)
            3'd2, 3'd5, 3'd6: w = 1'b1;
            default:          w = 1'b0;
        endcase
        return w;
    endfunction

    // byte lane index of a slot within its status word
    function automatic logic [1:0] slot_lane(input logic [2:0] slot);
        logic [1:0] l;
        case (slot)
            3'd0:       l = 2'd0;
            3'd1, 3'd2: l = 2'd1;
            3'd4, 3'd6: l = 2'd2;
            default:    l = 2'd3;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

@@ rtl/midplane_irq_status_registers.sv @@
// Midplane register block. One beat per cycle in and one result beat per cycle out:
// every command (bus read, bus write, net irq set/clear, insertion event) is decoded
// and applied to the registers at the edge where its beat is taken, and the result
// lands in an output register the next cycle; s_axis_tready stays high unless that
// register holds a result the sink has not taken. The command code travels on
// s_axis_tuser, the operands on s_axis_tdata. Each result carries the read value
// (zero for anything but a read), the masked network interrupt line as it stands after
// the command, and clear pulses for any access at 0x40 and 0x70. Reading 0x50 rebuilds
// the port adapter status from the bays-present register; 0x40 returns it masked.
`default_nettype none

`include "midplane_irq_status_registers_assert.svh"

module midplane_irq_status_registers (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // bays-present register write
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    // input beats
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // offset[7:0], write_data[39:8], slot[42:40], port[45:43], zero pad
    input  wire logic [47:0] s_axis_tdata,
    // cmd[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // result beats
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[31:0], net_irq_line[32], mgmt_irq_clear[33], oir_irq_clear[34], zero pad
    output logic [39:0]      m_axis_tdata
);

    mirq_pkg::t_item   w_item;
    mirq_pkg::t_result n_res;
    mirq_pkg::t_result r_res;

    logic        r_out_valid;
    logic        w_accept;

    logic [5:0]  r_bays;
    logic [31:0] r_nstat [2];
    logic [31:0] r_nmask [2];
    logic [31:0] r_snap;
    logic [31:0] r_ctrl;
    logic [7:0]  r_ins;

    logic [31:0] n_nstat [2];
    logic [31:0] n_nmask [2];
    logic [31:0] n_snap;
    logic [31:0] n_ctrl;
    logic [7:0]  n_ins;

    logic [31:0] w_built;
    logic [31:0] w_lane_bit;
    logic        w_word;

    // operands above the command code form one item
    assign w_item        = mirq_pkg::t_item'({s_axis_tdata[45:0], s_axis_tuser});
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(40 - $bits(mirq_pkg::t_result)){1'b0}}, r_res};

    // port adapter status from present bays
    always_comb begin
        w_built = mirq_pkg::BAY0_POWER;
        for (int i = 0; i < mirq_pkg::NUM_BAYS; i++) begin
            if (r_bays[i]) begin
                w_built = w_built | mirq_pkg::BAY_POWER[i];
            end
        end
    end

    // status bit for slot and port
    assign w_word     = mirq_pkg::slot_word(w_item.slot);
    assign w_lane_bit = 32'(1) << {mirq_pkg::slot_lane(w_item.slot), w_item.port};

    // command decode and next register values
    always_comb begin
        n_nstat = r_nstat;
        n_nmask = r_nmask;
        n_snap  = r_snap;
        n_ctrl  = r_ctrl;
        n_ins   = r_ins;
        n_res   = '0;
        unique case (w_item.cmd)
            mirq_pkg::CMD_READ, mirq_pkg::CMD_WRITE: begin
                unique case (w_item.offset) inside
                    [mirq_pkg::OFF_NSTAT0_LO:mirq_pkg::OFF_NSTAT0_HI]: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) n_res.read_data = r_nstat[0];
                    end
                    [mirq_pkg::OFF_NSTAT1_LO:mirq_pkg::OFF_NSTAT1_HI]: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) n_res.read_data = r_nstat[1];
                    end
                    mirq_pkg::OFF_NMASK0: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) n_res.read_data = r_nmask[0];
                        else n_nmask[0] = w_item.write_data;
                    end
                    mirq_pkg::OFF_NMASK1: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) n_res.read_data = r_nmask[1];
                        else n_nmask[1] = w_item.write_data;
                    end
                    mirq_pkg::OFF_MGMT: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) begin
                            n_res.read_data = mirq_pkg::MGMT_MASK & r_snap;
                        end
                        n_res.mgmt_irq_clear = 1'b1;
                    end
                    mirq_pkg::OFF_TEST: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) begin
                            n_res.read_data = mirq_pkg::TEST_VALUE;
                        end
                    end
                    mirq_pkg::OFF_PA_STATUS: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) begin
                            n_snap          = w_built;
                            n_res.read_data = w_built;
                        end
                    end
                    mirq_pkg::OFF_PA_CTRL: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) n_res.read_data = r_ctrl;
                        else n_ctrl = w_item.write_data;
                    end
                    mirq_pkg::OFF_OIR: begin
                        if (w_item.cmd == mirq_pkg::CMD_READ) begin
                            n_res.read_data = {24'd0, r_ins};
                        end else begin
                            n_ins = r_ins & ~w_item.write_data[7:0];
                        end
                        n_res.oir_irq_clear = 1'b1;
                    end
                    // reserved offset, silently ignored
                    mirq_pkg::OFF_SKIP: begin
                    end
                    default: begin
                    end
                endcase
            end
            mirq_pkg::CMD_SET: begin
                if (32'(w_item.slot) < mirq_pkg::NUM_SLOTS) begin
                    n_nstat[w_word] = r_nstat[w_word] | w_lane_bit;
                end
            end
            mirq_pkg::CMD_CLEAR: begin
                if (32'(w_item.slot) < mirq_pkg::NUM_SLOTS) begin
                    n_nstat[w_word] = r_nstat[w_word] & ~w_lane_bit;
                end
            end
            mirq_pkg::CMD_INSERT: begin
                n_ins = r_ins | w_item.write_data[7:0];
            end
            default: begin
            end
        endcase
        // interrupt line after this command
        n_res.net_irq_line = |((n_nstat[0] & n_nmask[0]) | (n_nstat[1] & n_nmask[1]));
    end

    // register state and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bays      <= '0;
            r_nstat[0]  <= '0;
            r_nstat[1]  <= '0;
            r_nmask[0]  <= '0;
            r_nmask[1]  <= '0;
            r_snap      <= '0;
            r_ctrl      <= '0;
            r_ins       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_bays <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_nstat     <= n_nstat;
                r_nmask     <= n_nmask;
                r_snap      <= n_snap;
                r_ctrl      <= n_ctrl;
                r_ins       <= n_ins;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    // checks
    `MIRQ_ASSERT_NEXT(a_irq_tracks_regs, w_accept,
        r_res.net_irq_line == |((r_nstat[0] & r_nmask[0]) | (r_nstat[1] & r_nmask[1])),
        "irq line in result disagrees with registers")
    `MIRQ_ASSERT_NEXT(a_nonread_zero, w_accept && (w_item.cmd != mirq_pkg::CMD_READ),
        r_out_valid && (r_res.read_data == 32'd0),
        "non-read beat returned nonzero data")
    `MIRQ_ASSERT_NEXT(a_insert_sets, w_accept && (w_item.cmd == mirq_pkg::CMD_INSERT),
        (r_ins & $past(w_item.write_data[7:0])) == $past(w_item.write_data[7:0]),
        "insertion event did not set status bits")
    `MIRQ_ASSERT_NOW(a_pulse_excl, r_out_valid,
        !(r_res.mgmt_irq_clear && r_res.oir_irq_clear),
        "both clear pulses in one result")

endmodule

`default_nettype wire

@@ tb/sv/midplane_irq_status_checker.sv @@
`timescale 1ns / 1ps

module midplane_irq_status_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // offset, write_data, slot, port, zero pad
    input  wire logic [47:0] i_s_tdata,
    // cmd
    input  wire logic [2:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // read_data, net_irq_line, mgmt_irq_clear, oir_irq_clear, zero pad
    input  wire logic [39:0] i_m_tdata,
    output int               o_outstanding,
    output int               o_errors
);
    import mirq_pkg::*;

    // predicted register state, status and mask as {word 1, word 0}
    logic [5:0]  bays_card;
    logic [63:0] irq_status;
    logic [63:0] irq_mask;
    logic [31:0] pa_snapshot;
    logic [31:0] pa_control;
    logic [7:0]  ins_status;

    t_result expected_results[$];
    int      mismatches = 0;

    assign o_errors = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // one-hot position of a slot/port in the 64-bit status pair
    function automatic logic [63:0] port_bit(input logic [2:0] slot, input logic [2:0] port);
        int base;
        case (slot)
            3'd0:    base = 0;
            3'd1:    base = 8;
            3'd2:    base = 40;
            3'd3:    base = 24;
            3'd4:    base = 16;
            3'd5:    base = 56;
            default: base = 48;
        endcase
        return 64'd1 << (base + int'(port));
    endfunction

    // port adapter status from the cards present
    function automatic logic [31:0] adapter_status();
        logic [31:0] v;
        v = BAY0_POWER;
        for (int i = 0; i < NUM_BAYS; i++)
            if (bays_card[i])
                v |= BAY_POWER[i];
        return v;
    endfunction

    // apply one command beat to the predicted state and form its result
    function automatic t_result apply_command(input t_item it);
        t_result     res;
        logic        rd;
        logic [63:0] hit;
        res = '0;
        rd  = (it.cmd == CMD_READ);
        if ((it.cmd == CMD_READ || it.cmd == CMD_WRITE) && it.offset != OFF_SKIP) begin
            if (it.offset >= OFF_NSTAT0_LO && it.offset <= OFF_NSTAT0_HI) begin
                if (rd) res.read_data = irq_status[31:0];
            end else if (it.offset >= OFF_NSTAT1_LO && it.offset <= OFF_NSTAT1_HI) begin
                if (rd) res.read_data = irq_status[63:32];
            end else begin
                case (it.offset)
                    OFF_NMASK0: begin
                        if (rd) res.read_data = irq_mask[31:0];
                        else irq_mask[31:0] = it.write_data;
                    end
                    OFF_NMASK1: begin
                        if (rd) res.read_data = irq_mask[63:32];
                        else irq_mask[63:32] = it.write_data;
                    end
                    OFF_MGMT: begin
                        if (rd) res.read_data = MGMT_MASK & pa_snapshot;
                        res.mgmt_irq_clear = 1'b1;
                    end
                    OFF_TEST: begin
                        if (rd) res.read_data = TEST_VALUE;
                    end
                    OFF_PA_STATUS: begin
                        if (rd) begin
                            pa_snapshot   = adapter_status();
                            res.read_data = pa_snapshot;
                        end
                    end
                    OFF_PA_CTRL: begin
                        if (rd) res.read_data = pa_control;
                        else pa_control = it.write_data;
                    end
                    OFF_OIR: begin
                        if (rd) res.read_data = {24'd0, ins_status};
                        else ins_status &= ~it.write_data[7:0];
                        res.oir_irq_clear = 1'b1;
                    end
                    default: ;
                endcase
            end
        end else if ((it.cmd == CMD_SET || it.cmd == CMD_CLEAR) && it.slot < NUM_SLOTS) begin
            hit = port_bit(it.slot, it.port);
            if (it.cmd == CMD_SET) irq_status |= hit;
            else irq_status &= ~hit;
        end else if (it.cmd == CMD_INSERT) begin
            ins_status |= it.write_data[7:0];
        end
        res.net_irq_line = |(irq_status & irq_mask);
        return res;
    endfunction

    // watch both channels and the register write
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            bays_card   = '0;
            irq_status  = '0;
            irq_mask    = '0;
            pa_snapshot = '0;
            pa_control  = '0;
            ins_status  = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                bays_card = i_cfg_wdata;
            // compare a result beat against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[$bits(t_result)-1:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result beat", got.read_data, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.net_irq_line !== want.net_irq_line)
                        report_mismatch("net_irq_line", 32'(got.net_irq_line),
                                        32'(want.net_irq_line));
                    if (got.mgmt_irq_clear !== want.mgmt_irq_clear)
                        report_mismatch("mgmt_irq_clear", 32'(got.mgmt_irq_clear),
                                        32'(want.mgmt_irq_clear));
                    if (got.oir_irq_clear !== want.oir_irq_clear)
                        report_mismatch("oir_irq_clear", 32'(got.oir_irq_clear),
                                        32'(want.oir_irq_clear));
                end
            end
            // predict the result of an accepted command beat, operands above the code
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(
                    apply_command(t_item'({i_s_tdata[45:0], i_s_tuser})));
        end
        o_outstanding <= expected_results.size();
    end

endmodule

@@ tb/sv/midplane_irq_status_registers_tb.sv @@
`timescale 1ns / 1ps

module midplane_irq_status_registers_tb;
    import mirq_pkg::*;

    // unmapped offsets and the top command code
    localparam logic [7:0] OFF_EEPROM0  = 8'h60;
    localparam logic [7:0] OFF_EEPROM1  = 8'h68;
    localparam logic [7:0] OFF_SPARE0   = 8'h78;
    localparam logic [7:0] OFF_SPARE1   = 8'h38;
    localparam logic [2:0] CMD_MAX_CODE = 3'h7;

    localparam int PHASE_BEATS = 330;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [5:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    int outstanding;
    int errors;

    bit send_quiet = 1'b0;
    int stall_left = 0;
    int ready_run  = 0;
    int stall_pick;

    midplane_irq_status_registers dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    midplane_irq_status_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result sink: short and long stalls, with runs of steady ready
    always @(posedge i_clk) begin
        if (ready_run > 0) begin
            ready_run--;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 3)
                ready_run = $urandom_range(20, 80);
            else if (stall_pick < 22)
                stall_left = $urandom_range(1, 3);
            else if (stall_pick < 25)
                stall_left = $urandom_range(8, 30);
        end
    end

    function automatic t_item beat(input logic [2:0] cmd, input logic [7:0] offset,
                                   input logic [31:0] data, input logic [2:0] slot,
                                   input logic [2:0] port);
        t_item it;
        it.cmd        = cmd;
        it.offset     = offset;
        it.write_data = data;
        it.slot       = slot;
        it.port       = port;
        return it;
    endfunction

    // any register offset, mapped or not
    function automatic logic [7:0] pick_offset();
        logic [7:0] off;
        case ($urandom_range(0, 14))
            0:       off = OFF_NSTAT0_LO + 8'($urandom_range(0, 3));
            1:       off = OFF_NSTAT1_LO + 8'($urandom_range(0, 3));
            2, 3:    off = OFF_NMASK0;
            4, 5:    off = OFF_NMASK1;
            6:       off = OFF_MGMT;
            7:       off = OFF_TEST;
            8:       off = OFF_PA_STATUS;
            9:       off = OFF_PA_CTRL;
            10, 11:  off = OFF_OIR;
            12:      off = OFF_SKIP;
            13:      off = ($urandom_range(0, 1) != 0) ? OFF_EEPROM0 : OFF_EEPROM1;
            default: off = ($urandom_range(0, 1) != 0) ? OFF_SPARE0 : OFF_SPARE1;
        endcase
        return off;
    endfunction

    // mask values: full, empty, dense and sparse
    function automatic logic [31:0] mask_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = '1;
            1:       v = '0;
            2:       v = $urandom();
            default: v = $urandom() & $urandom();
        endcase
        return v;
    endfunction

    function automatic t_item random_beat();
        t_item       it;
        int          pick;
        logic [7:0]  off;
        pick = $urandom_range(0, 99);
        it   = beat(CMD_READ, 8'($urandom_range(0, 255)), $urandom(),
                    3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        if (pick < 30) begin
            // interrupt events, slot mostly in range
            it.cmd = ($urandom_range(0, 99) < 55) ? CMD_SET : CMD_CLEAR;
            if ($urandom_range(0, 19) != 0)
                it.slot = 3'($urandom_range(0, NUM_SLOTS - 1));
        end else if (pick < 58) begin
            it.offset = pick_offset();
        end else if (pick < 74) begin
            off           = pick_offset();
            it.cmd        = CMD_WRITE;
            it.offset     = off;
            if (off == OFF_NMASK0 || off == OFF_NMASK1)
                it.write_data = mask_value();
        end else if (pick < 84) begin
            it.cmd = CMD_INSERT;
        end else if (pick < 95) begin
            it.cmd = ($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ;
        end else begin
            it.cmd = 3'($urandom_range(int'(CMD_INSERT) + 1, int'(CMD_MAX_CODE)));
        end
        return it;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one command beat, after an optional gap
    task automatic send_beat(input t_item it);
        int gap;
        if ($urandom_range(0, 63) == 0)
            send_quiet = !send_quiet;
        gap = pick_gap(send_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= 48'({it.port, it.slot, it.write_data, it.offset});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and wait for every predicted result
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic set_bays(input logic [5:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every register, both interrupt words, edge slots and codes
        set_bays('1);
        send_beat(beat(CMD_READ,   OFF_TEST,      '0,           3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_MGMT,      '0,           3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_PA_STATUS, '0,           3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_MGMT,      '0,           3'd0, 3'd0));
        send_beat(beat(CMD_WRITE,  OFF_MGMT,      '1,           3'd0, 3'd0));
        send_beat(beat(CMD_WRITE,  OFF_NMASK0,    '1,           3'd0, 3'd0));
        send_beat(beat(CMD_WRITE,  OFF_NMASK1,    '1,           3'd0, 3'd0));
        send_beat(beat(CMD_SET,    '0,            '0,           3'd0, 3'd0));
        send_beat(beat(CMD_SET,    '0,            '0,           3'd6, 3'd7));
        send_beat(beat(CMD_SET,    '0,            '0,           3'd7, 3'd3));
        send_beat(beat(CMD_READ,   OFF_NSTAT0_HI, '0,           3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_NSTAT1_LO, '0,           3'd0, 3'd0));
        send_beat(beat(CMD_WRITE,  OFF_NSTAT0_LO, '1,           3'd0, 3'd0));
        send_beat(beat(CMD_CLEAR,  '0,            '0,           3'd0, 3'd0));
        send_beat(beat(CMD_CLEAR,  '0,            '0,           3'd6, 3'd7));
        send_beat(beat(CMD_INSERT, '0,            '1,           3'd0, 3'd0));
        send_beat(beat(CMD_WRITE,  OFF_OIR,       32'h0000_000f, 3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_OIR,       '0,           3'd0, 3'd0));
        send_beat(beat(CMD_WRITE,  OFF_PA_CTRL,   '1,           3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_PA_CTRL,   '0,           3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_SKIP,      '0,           3'd0, 3'd0));
        send_beat(beat(CMD_WRITE,  OFF_SKIP,      '1,           3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_SPARE1,    '0,           3'd0, 3'd0));
        send_beat(beat(CMD_MAX_CODE, OFF_OIR,     '1,           3'd7, 3'd7));
        send_beat(beat(CMD_WRITE,  OFF_NMASK0,    '0,           3'd0, 3'd0));
        send_beat(beat(CMD_READ,   OFF_NMASK1,    '0,           3'd0, 3'd0));

        // random phases, each under its own set of cards
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       set_bays('0);
                2:       set_bays('1);
                default: set_bays(6'($urandom_range(0, 63)));
            endcase
            repeat (PHASE_BEATS) send_beat(random_beat());
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
